// File: sv/layered_stacking_order_list_top_assert.svh
// Assertion macros used by the stacking order list datapath.
`ifndef LAYERED_STACKING_ORDER_LIST_TOP_ASSERT_SVH
`define LAYERED_STACKING_ORDER_LIST_TOP_ASSERT_SVH
`ifndef SYNTH
`define LSOL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LSOL_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LSOL_ASSERT(name, prop, msg)
`define LSOL_ASSERT_RST(name, prop, msg)
`endif
`endif

// File: sv/lsol_pkg.sv
// Types and constants of the layered stacking order list.
`timescale 1ns / 1ps
`default_nettype none
package lsol_pkg;

  localparam int unsigned LSOL_MAX_ENTRIES = 64;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned LAYER_W = 3;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned STAT_W  = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_RAISE  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_LOWER  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CHANGE = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  localparam logic [LAYER_W-1:0] LAYER_DESKTOP    = 3'd0;
  localparam logic [LAYER_W-1:0] LAYER_FULLSCREEN = 3'd4;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_ZERO,
    RD_IDX_P1
  } lsol_rd_e;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [ID_W-1:0]    id;
  } lsol_entry_t;

  typedef struct packed {
    logic              req_ready;
    logic              latch;
    logic              idx_clr;
    logic              idx_inc;
    logic              idx_dec;
    logic              idx_ld_occ;
    logic              pos_ld;
    logic              stored_ld;
    logic              occ_inc;
    logic              occ_dec;
    lsol_rd_e          rd_sel;
    logic              wr_en;
    logic              wr_new;
    logic              place_ld;
    logic              place_stored;
    logic              place_bottom;
    logic              st_ld;
    logic [STAT_W-1:0] st_code;
    logic              fb_clr;
    logic              front_ld;
    logic              back_ld;
    logic              out_ld;
  } lsol_cmd_t;

  typedef struct packed {
    logic              req_valid;
    logic [ACT_W-1:0]  act;
    logic              idx_at_occ;
    logic              idx_last;
    logic              idx_eq_pos;
    logic              id_match;
    logic              layer_nz;
    logic              slot_hit;
    logic              occ_zero;
    logic              occ_full;
    logic              out_free;
  } lsol_sts_t;

endpackage
`default_nettype wire

// File: sv/lsol_if.sv
// Request and response channel interfaces of the stacking order list.
`timescale 1ns / 1ps
`default_nettype none
interface lsol_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] entity;
  logic [2:0] layer;
  modport source (output valid, action, entity, layer, input ready);
  modport sink (input valid, action, entity, layer, output ready);
endinterface

interface lsol_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] front_entity;
  logic       front_valid;
  logic [7:0] back_entity;
  logic       back_valid;
  modport source (output valid, status, front_entity, front_valid, back_entity, back_valid,
                  input ready);
  modport sink (input valid, status, front_entity, front_valid, back_entity, back_valid,
                output ready);
endinterface
`default_nettype wire

// File: sv/lsol_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lsol_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// File: sv/lsol_ctrl.sv
// Sequencer for the stacking order list: find, drop, slot search, shift, front/back scan.
`timescale 1ns / 1ps
`default_nettype none
module lsol_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lsol_pkg::lsol_sts_t sts_i,
  output lsol_pkg::lsol_cmd_t     cmd_o
);
  import lsol_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DISPATCH  = 4'd1;
  localparam logic [3:0] S_FIND_RD   = 4'd2;
  localparam logic [3:0] S_FIND_CHK  = 4'd3;
  localparam logic [3:0] S_DROP_RD   = 4'd4;
  localparam logic [3:0] S_DROP_WR   = 4'd5;
  localparam logic [3:0] S_SLOT_RD   = 4'd6;
  localparam logic [3:0] S_SLOT_CHK  = 4'd7;
  localparam logic [3:0] S_SHIFT_RD  = 4'd8;
  localparam logic [3:0] S_SHIFT_WR  = 4'd9;
  localparam logic [3:0] S_FRONT_RD  = 4'd10;
  localparam logic [3:0] S_FRONT_CHK = 4'd11;
  localparam logic [3:0] S_BACK_RD   = 4'd12;
  localparam logic [3:0] S_BACK_CHK  = 4'd13;
  localparam logic [3:0] S_DONE      = 4'd14;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    cmd_o.rd_sel = RD_IDX;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.req_ready = 1'b1;
        if (sts_i.req_valid) begin
          cmd_o.latch = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts_i.act)
          ACT_INSERT, ACT_APPEND: begin
            if (sts_i.occ_full) begin
              cmd_o.st_ld   = 1'b1;
              cmd_o.st_code = ST_FULL;
              state_d = S_FRONT_RD;
            end else begin
              cmd_o.place_ld     = 1'b1;
              cmd_o.place_bottom = (sts_i.act == ACT_APPEND);
              cmd_o.idx_clr      = 1'b1;
              state_d = S_SLOT_RD;
            end
          end
          ACT_REMOVE, ACT_RAISE, ACT_LOWER, ACT_CHANGE: begin
            cmd_o.idx_clr = 1'b1;
            state_d = S_FIND_RD;
          end
          default: state_d = S_FRONT_RD;
        endcase
      end
      S_FIND_RD: begin
        if (sts_i.idx_at_occ) begin
          cmd_o.st_ld   = 1'b1;
          cmd_o.st_code = ST_NOT_FOUND;
          state_d = S_FRONT_RD;
        end else begin
          state_d = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if (sts_i.id_match) begin
          cmd_o.stored_ld = 1'b1;
          state_d = S_DROP_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_FIND_RD;
        end
      end
      S_DROP_RD: begin
        // read the entry below idx; when idx is the last entry the drop is done
        if (sts_i.idx_last) begin
          cmd_o.occ_dec = 1'b1;
          if (sts_i.act == ACT_REMOVE) begin
            state_d = S_FRONT_RD;
          end else begin
            cmd_o.place_ld     = 1'b1;
            cmd_o.place_stored = (sts_i.act != ACT_CHANGE);
            cmd_o.place_bottom = (sts_i.act == ACT_LOWER);
            cmd_o.idx_clr      = 1'b1;
            state_d = S_SLOT_RD;
          end
        end else begin
          cmd_o.rd_sel = RD_IDX_P1;
          state_d = S_DROP_WR;
        end
      end
      S_DROP_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_inc = 1'b1;
        state_d = S_DROP_RD;
      end
      S_SLOT_RD: begin
        if (sts_i.idx_at_occ) begin
          cmd_o.pos_ld     = 1'b1;
          cmd_o.idx_ld_occ = 1'b1;
          state_d = S_SHIFT_RD;
        end else begin
          state_d = S_SLOT_CHK;
        end
      end
      S_SLOT_CHK: begin
        if (sts_i.slot_hit) begin
          cmd_o.pos_ld     = 1'b1;
          cmd_o.idx_ld_occ = 1'b1;
          state_d = S_SHIFT_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_SLOT_RD;
        end
      end
      S_SHIFT_RD: begin
        if (sts_i.idx_eq_pos) begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_new  = 1'b1;
          cmd_o.occ_inc = 1'b1;
          state_d = S_FRONT_RD;
        end else begin
          cmd_o.rd_sel = RD_IDX_M1;
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.idx_dec = 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_FRONT_RD: begin
        cmd_o.fb_clr = 1'b1;
        cmd_o.rd_sel = RD_ZERO;
        state_d = sts_i.occ_zero ? S_DONE : S_FRONT_CHK;
      end
      S_FRONT_CHK: begin
        cmd_o.front_ld = 1'b1;
        // list is sorted by layer: a desktop top entry means no back either
        if (sts_i.layer_nz) begin
          cmd_o.idx_ld_occ = 1'b1;
          state_d = S_BACK_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_BACK_RD: begin
        cmd_o.rd_sel = RD_IDX_M1;
        state_d = S_BACK_CHK;
      end
      S_BACK_CHK: begin
        if (sts_i.layer_nz) begin
          cmd_o.back_ld = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.idx_dec = 1'b1;
          state_d = S_BACK_RD;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: sv/lsol_dp.sv
// Datapath: order RAM, index and occupancy counters, result register.
`timescale 1ns / 1ps
`default_nettype none
`include "layered_stacking_order_list_top_assert.svh"
module lsol_dp #(
  parameter int unsigned MaxEntries = lsol_pkg::LSOL_MAX_ENTRIES
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  lsol_req_if.sink                 req,
  lsol_rsp_if.source               rsp,
  input  wire lsol_pkg::lsol_cmd_t cmd_i,
  output lsol_pkg::lsol_sts_t      sts_o
);
  import lsol_pkg::*;

  localparam int unsigned AW = $clog2(MaxEntries);
  localparam int unsigned CW = $clog2(MaxEntries + 1);

  logic [ACT_W-1:0]   act_q;
  logic [ID_W-1:0]    id_q;
  logic [LAYER_W-1:0] lay_q;
  logic [LAYER_W-1:0] place_lay_q;
  logic               bottom_q;
  logic [LAYER_W-1:0] stored_q;
  logic [CW-1:0]      idx_q, pos_q, occ_q;
  logic [STAT_W-1:0]  status_q;
  logic [ID_W-1:0]    front_id_q, back_id_q;
  logic               front_v_q, back_v_q;

  logic               rsp_valid_q;
  logic [STAT_W-1:0]  rsp_status_q;
  logic [ID_W-1:0]    rsp_front_q, rsp_back_q;
  logic               rsp_front_v_q, rsp_back_v_q;

  lsol_entry_t        rdata, wdata;
  logic [CW-1:0]      raddr;
  logic [CW-1:0]      idx_m1;
  logic [CW-1:0]      idx_p1;
  logic               accept;

  assign accept = req.valid & req.ready;
  assign req.ready = cmd_i.req_ready;
  assign idx_m1 = idx_q - CW'(1);
  assign idx_p1 = idx_q + CW'(1);

  always_comb begin
    case (cmd_i.rd_sel)
      RD_IDX:    raddr = idx_q;
      RD_IDX_M1: raddr = idx_m1;
      RD_ZERO:   raddr = '0;
      RD_IDX_P1: raddr = idx_p1;
      default:   raddr = idx_q;
    endcase
  end

  assign wdata = cmd_i.wr_new ? lsol_entry_t'({place_lay_q, id_q}) : rdata;

  lsol_ram #(
    .Width(LAYER_W + ID_W),
    .Depth(MaxEntries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en),
    .waddr_i(idx_q[AW-1:0]),
    .wdata_i(wdata),
    .raddr_i(raddr[AW-1:0]),
    .rdata_o(rdata)
  );

  // payload of the item in flight, plus working indices, status, front/back and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q <= req.action;
      id_q  <= req.entity;
      lay_q <= (req.layer > LAYER_FULLSCREEN) ? LAYER_FULLSCREEN : req.layer;
    end
    if (cmd_i.place_ld) begin
      place_lay_q <= cmd_i.place_stored ? stored_q : lay_q;
      bottom_q    <= cmd_i.place_bottom;
    end
    if (cmd_i.stored_ld) begin
      stored_q <= rdata.layer;
    end
    if (cmd_i.pos_ld) begin
      pos_q <= idx_q;
    end
    if (cmd_i.idx_clr) begin
      idx_q <= '0;
    end else if (cmd_i.idx_ld_occ) begin
      idx_q <= occ_q;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_p1;
    end else if (cmd_i.idx_dec) begin
      idx_q <= idx_m1;
    end
    if (cmd_i.latch) begin
      status_q <= ST_OK;
    end else if (cmd_i.st_ld) begin
      status_q <= cmd_i.st_code;
    end
    if (cmd_i.fb_clr) begin
      front_id_q <= '0;
      front_v_q  <= 1'b0;
      back_id_q  <= '0;
      back_v_q   <= 1'b0;
    end
    if (cmd_i.front_ld) begin
      front_v_q  <= (rdata.layer != LAYER_DESKTOP);
      front_id_q <= (rdata.layer != LAYER_DESKTOP) ? rdata.id : '0;
    end
    if (cmd_i.back_ld) begin
      back_v_q  <= 1'b1;
      back_id_q <= rdata.id;
    end
    if (cmd_i.out_ld) begin
      rsp_status_q  <= status_q;
      rsp_front_q   <= front_id_q;
      rsp_front_v_q <= front_v_q;
      rsp_back_q    <= back_id_q;
      rsp_back_v_q  <= back_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.occ_inc) begin
        occ_q <= occ_q + CW'(1);
      end else if (cmd_i.occ_dec) begin
        occ_q <= occ_q - CW'(1);
      end
      if (cmd_i.out_ld) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp.valid        = rsp_valid_q;
  assign rsp.status       = rsp_status_q;
  assign rsp.front_entity = rsp_front_q;
  assign rsp.front_valid  = rsp_front_v_q;
  assign rsp.back_entity  = rsp_back_q;
  assign rsp.back_valid   = rsp_back_v_q;

  always_comb begin
    sts_o.req_valid  = req.valid;
    sts_o.act        = act_q;
    sts_o.idx_at_occ = (idx_q == occ_q);
    sts_o.idx_last   = (idx_p1 >= occ_q);
    sts_o.idx_eq_pos = (idx_q == pos_q);
    sts_o.id_match   = (rdata.id == id_q);
    sts_o.layer_nz   = (rdata.layer != LAYER_DESKTOP);
    sts_o.slot_hit   = bottom_q ? (rdata.layer < place_lay_q) : (rdata.layer <= place_lay_q);
    sts_o.occ_zero   = (occ_q == '0);
    sts_o.occ_full   = (occ_q >= CW'(MaxEntries));
    sts_o.out_free   = !rsp_valid_q || rsp.ready;
  end

  `LSOL_ASSERT(a_occ_bound, occ_q <= CW'(MaxEntries), "occupancy above capacity")
  `LSOL_ASSERT(a_wr_in_list, cmd_i.wr_en |-> (idx_q <= occ_q), "write beyond list end")
  `LSOL_ASSERT(a_fb_pair, rsp_valid_q |-> (rsp_front_v_q == rsp_back_v_q), "front/back flag mismatch")
  `LSOL_ASSERT(a_no_accept_busy, accept |=> !req.ready, "beat accepted while busy")
  `LSOL_ASSERT_RST(a_rst_rsp, !rst_ni |=> !rsp_valid_q, "response valid out of reset")
endmodule
`default_nettype wire

// File: sv/layered_stacking_order_list_top.sv
// Top level of the layered stacking order list.
// One action beat in, one result beat out. Entries live in an order RAM with one
// write port and one registered read port, sorted top to bottom by layer; each
// action walks it one entry at a time in some of these passes: a find pass, a
// drop shift, a slot search, an insert shift and a back-entity scan. A new beat
// is taken once the previous result sits in the output register; no clearing
// pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module layered_stacking_order_list_top #(
  parameter int unsigned MaxEntries = lsol_pkg::LSOL_MAX_ENTRIES
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lsol_req_if.sink   req_i,
  lsol_rsp_if.source rsp_o
);
  import lsol_pkg::*;

  lsol_cmd_t cmd;
  lsol_sts_t sts;

  lsol_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  lsol_dp #(
    .MaxEntries(MaxEntries)
  ) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_i),
    .rsp   (rsp_o),
    .cmd_i (cmd),
    .sts_o (sts)
  );
endmodule
`default_nettype wire

// File: verif/lsol_checker.sv
// Checker for the stacking order list: mirrors the list, predicts each result, compares.
`timescale 1ns / 1ps
`default_nettype none
module lsol_checker
  import lsol_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lsol_req_if       req,
  lsol_rsp_if       rsp,
  output int        errors_o,
  output int        pending_o
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   front_entity;
    logic              front_valid;
    logic [ID_W-1:0]   back_entity;
    logic              back_valid;
  } stack_view_t;

  logic [ID_W-1:0]    ids[LSOL_MAX_ENTRIES];
  logic [LAYER_W-1:0] lays[LSOL_MAX_ENTRIES];
  int                 count;
  stack_view_t        expected_views[$];
  int                 errors;

  assign errors_o  = errors;
  assign pending_o = expected_views.size();

  function automatic int slot_for(logic [LAYER_W-1:0] lay, bit at_bottom);
    int i;
    for (i = 0; i < count; i++)
      if (at_bottom ? (lays[i] < lay) : (lays[i] <= lay)) break;
    return i;
  endfunction

  task automatic place(logic [ID_W-1:0] id, logic [LAYER_W-1:0] lay, bit at_bottom);
    int pos;
    pos = slot_for(lay, at_bottom);
    for (int j = count; j > pos; j--) begin
      ids[j]  = ids[j-1];
      lays[j] = lays[j-1];
    end
    ids[pos]  = id;
    lays[pos] = lay;
    count++;
  endtask

  task automatic drop(int pos);
    for (int j = pos; j < count - 1; j++) begin
      ids[j]  = ids[j+1];
      lays[j] = lays[j+1];
    end
    count--;
  endtask

  task automatic apply_action(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                              logic [LAYER_W-1:0] lay_in);
    logic [LAYER_W-1:0] lay, stored;
    stack_view_t v;
    int pos;
    lay = (lay_in > LAYER_FULLSCREEN) ? LAYER_FULLSCREEN : lay_in;
    v = '0;
    v.status = ST_OK;
    case (act)
      ACT_INSERT, ACT_APPEND: begin
        if (count >= LSOL_MAX_ENTRIES) v.status = ST_FULL;
        else place(id, lay, act == ACT_APPEND);
      end
      ACT_REMOVE, ACT_RAISE, ACT_LOWER, ACT_CHANGE: begin
        pos = -1;
        for (int i = 0; i < count; i++)
          if (pos < 0 && ids[i] == id) pos = i;
        if (pos < 0) v.status = ST_NOT_FOUND;
        else begin
          stored = lays[pos];
          drop(pos);
          if (act == ACT_RAISE) place(id, stored, 1'b0);
          else if (act == ACT_LOWER) place(id, stored, 1'b1);
          else if (act == ACT_CHANGE) place(id, lay, 1'b0);
        end
      end
      default: ;
    endcase
    if (count > 0 && lays[0] != LAYER_DESKTOP) begin
      v.front_entity = ids[0];
      v.front_valid  = 1'b1;
    end
    for (int i = count - 1; i >= 0; i--)
      if (!v.back_valid && lays[i] != LAYER_DESKTOP) begin
        v.back_entity = ids[i];
        v.back_valid  = 1'b1;
      end
    expected_views.push_back(v);
  endtask

  task automatic report(string what, int got, int want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stack_view_t w;
    if (!rst_ni) begin
      count  <= 0;
      errors <= 0;
      expected_views.delete();
    end else begin
      if (req.valid && req.ready) apply_action(req.action, req.entity, req.layer);
      if (rsp.valid && rsp.ready) begin
        if (expected_views.size() == 0) begin
          $display("%0t unexpected result beat", $time);
          errors++;
        end else begin
          w = expected_views.pop_front();
          if (rsp.status !== w.status) report("status", rsp.status, w.status);
          if (rsp.front_valid !== w.front_valid)
            report("front_valid", rsp.front_valid, w.front_valid);
          if (rsp.front_entity !== w.front_entity)
            report("front_entity", rsp.front_entity, w.front_entity);
          if (rsp.back_valid !== w.back_valid)
            report("back_valid", rsp.back_valid, w.back_valid);
          if (rsp.back_entity !== w.back_entity)
            report("back_entity", rsp.back_entity, w.back_entity);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: verif/layered_stacking_order_list_top_test.sv
// Testbench top: drives actions on the stacking order list and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module layered_stacking_order_list_top_test;
  import lsol_pkg::*;

  localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd6;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending;
  int   send_idle_pct, recv_stall_pct;
  logic [ID_W-1:0] id_pool;

  lsol_req_if req();
  lsol_rsp_if rsp();

  layered_stacking_order_list_top u_dut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req),
                                         .rsp_o(rsp));
  lsol_checker u_chk (.clk_i(clk_i), .rst_ni(rst_ni), .req(req), .rsp(rsp),
                      .errors_o(errors), .pending_o(pending));

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver stalls at random, rate set per phase
  always @(posedge clk_i)
    rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send_beat(logic [ACT_W-1:0] act, logic [ID_W-1:0] id,
                           logic [LAYER_W-1:0] lay);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid  <= 1'b1;
    req.action <= act;
    req.entity <= id;
    req.layer  <= lay;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic drain;
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // mostly a small ID pool so finds hit and duplicates occur
  task automatic random_beat;
    logic [ID_W-1:0] id;
    logic [ACT_W-1:0] act;
    int r;
    r = $urandom_range(99);
    id = (r < 80) ? (id_pool ^ ID_W'($urandom_range(15))) : ID_W'($urandom);
    r = $urandom_range(99);
    if (r < 35) act = ACT_INSERT;
    else if (r < 50) act = ACT_APPEND;
    else if (r < 65) act = ACT_REMOVE;
    else act = ACT_W'($urandom_range(7));
    send_beat(act, id, LAYER_W'($urandom_range(7)));
  endtask

  initial begin
    req.valid = 1'b0;
    req.action = '0;
    req.entity = '0;
    req.layer = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    id_pool = 8'h40;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty list, extremes, every action
    send_beat(ACT_QUERY, 8'h00, 3'd0);
    send_beat(ACT_REMOVE, 8'hff, 3'd0);
    send_beat(ACT_RAISE, 8'h01, 3'd0);
    send_beat(ACT_LOWER, 8'h01, 3'd0);
    send_beat(ACT_CHANGE, 8'h01, 3'd2);
    send_beat(ACT_INSERT, 8'h00, LAYER_DESKTOP);
    send_beat(ACT_QUERY, 8'h00, 3'd0);
    send_beat(ACT_INSERT, 8'hff, 3'd7);
    send_beat(ACT_APPEND, 8'h11, 3'd1);
    send_beat(ACT_INSERT, 8'h22, 3'd2);
    send_beat(ACT_APPEND, 8'h22, 3'd5);
    send_beat(ACT_INSERT, 8'h33, 3'd3);
    send_beat(ACT_RAISE, 8'h22, 3'd0);
    send_beat(ACT_LOWER, 8'hff, 3'd0);
    send_beat(ACT_CHANGE, 8'h11, 3'd6);
    send_beat(ACT_CHANGE, 8'h00, 3'd4);
    send_beat(ACT_UNUSED, 8'h22, 3'd3);
    send_beat(ACT_REMOVE, 8'h22, 3'd0);
    // fill to full, then overflow both ways and change layer while full
    for (int i = 0; i < LSOL_MAX_ENTRIES; i++)
      send_beat(ACT_W'(i % 2), ID_W'(8'h80 + i), LAYER_W'($urandom_range(7)));
    send_beat(ACT_INSERT, 8'haa, 3'd2);
    send_beat(ACT_APPEND, 8'h55, 3'd0);
    send_beat(ACT_CHANGE, 8'h85, 3'd0);
    drain();  // sender holds off until every result is in
    for (int i = 0; i < LSOL_MAX_ENTRIES + 4; i++)
      send_beat(ACT_REMOVE, ID_W'(8'h80 + i), 3'd0);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        3: begin send_idle_pct = 20; recv_stall_pct = 20; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 300; n++) begin
        if (n % 60 == 0) id_pool = ID_W'($urandom);
        random_beat();
      end
    end
    drain();
    repeat (400) @(posedge clk_i);
    if (errors == 0) $display("layered_stacking_order_list_top_test OK");
    else $display("layered_stacking_order_list_top_test NOT OK");
    $finish;
  end

  initial begin
    #60ms;
    $display("layered_stacking_order_list_top_test NOT OK");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/lsol_pkg.sv
sv/lsol_if.sv
sv/lsol_ram.sv
sv/lsol_ctrl.sv
sv/lsol_dp.sv
sv/layered_stacking_order_list_top.sv
verif/lsol_checker.sv
verif/layered_stacking_order_list_top_test.sv
